>>> src/bnpr_pkg.sv
`default_nettype none

package bnpr_pkg;

  // Default coordinate format of the ports.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Width of the intermediate fixed-point values; some sums and the divider use wider ones.
  localparam int XW = 64;

  // Register stages of one fixed-point product.
  localparam int MUL_LAT = 3;

  // Configuration register indexes.
  localparam int REG_CTRL0_X = 0;
  localparam int REG_CTRL0_Y = 1;
  localparam int REG_CTRL1_X = 2;
  localparam int REG_CTRL1_Y = 3;
  localparam int REG_CTRL2_X = 4;
  localparam int REG_CTRL2_Y = 5;
  localparam int REG_CTRL3_X = 6;
  localparam int REG_CTRL3_Y = 7;
  localparam int NREG        = REG_CTRL3_Y + 1;
  localparam int REG_SEL_W   = $clog2(NREG);
  localparam int CFG_IDX_W   = REG_SEL_W + 1;

  localparam logic signed [XW-1:0] S64_MAX = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0] S64_MIN = {1'b1, {(XW-1){1'b0}}};

  // Puts the sign on a magnitude; hi_nz flags set bits above the low word.
  function automatic logic signed [XW-1:0] apply_sign(input logic hi_nz,
                                                      input logic [XW-1:0] m,
                                                      input logic neg);
    if (neg) begin
      if (hi_nz || m[XW-1]) return S64_MIN;
      return -$signed(m);
    end
    if (hi_nz || m[XW-1]) return S64_MAX;
    return $signed(m);
  endfunction

endpackage

`default_nettype wire

>>> src/bnpr_ifs.sv
`default_nettype none

interface bnpr_query_if #(parameter int W = bnpr_pkg::COORD_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] param_u;
  modport source (output valid, point_x, point_y, param_u, input ready);
  modport sink (input valid, point_x, point_y, param_u, output ready);
endinterface

interface bnpr_answer_if #(parameter int W = bnpr_pkg::COORD_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] refined_u;
  logic                zero_denominator;
  logic                saturated;
  modport source (output valid, refined_u, zero_denominator, saturated, input ready);
  modport sink (input valid, refined_u, zero_denominator, saturated, output ready);
endinterface

`default_nettype wire

>>> src/bnpr_fxmul.sv
`default_nettype none

// Fixed-point product of two 64-bit signed values: the exact magnitude product
// is cut into four 32x32 partial products, then shifted right by the fraction
// bits (truncation toward zero) and saturated to 64 bits.
module bnpr_fxmul #(
  parameter int FRAC_BITS = bnpr_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [bnpr_pkg::XW-1:0] a,
  input  logic signed [bnpr_pkg::XW-1:0] b,
  output logic signed [bnpr_pkg::XW-1:0] p
);
  import bnpr_pkg::*;

  localparam int HW = XW / 2;

  logic [XW-1:0]   ma, mb;
  logic            neg1, neg2;
  logic [XW-1:0]   p00, p01, p10, p11;
  logic [2*XW-1:0] full, shifted;

  always_comb begin
    full = {{XW{1'b0}}, p00}
         + ({{XW{1'b0}}, p01} << HW)
         + ({{XW{1'b0}}, p10} << HW)
         + {p11, {XW{1'b0}}};
    shifted = full >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= a[XW-1] ? XW'(-a) : XW'(a);
      mb   <= b[XW-1] ? XW'(-b) : XW'(b);
      neg1 <= a[XW-1] ^ b[XW-1];
      p00  <= XW'(ma[HW-1:0]) * XW'(mb[HW-1:0]);
      p01  <= XW'(ma[HW-1:0]) * XW'(mb[XW-1:HW]);
      p10  <= XW'(ma[XW-1:HW]) * XW'(mb[HW-1:0]);
      p11  <= XW'(ma[XW-1:HW]) * XW'(mb[XW-1:HW]);
      neg2 <= neg1;
      p    <= apply_sign(|shifted[2*XW-1:XW], shifted[XW-1:0], neg2);
    end
  end

endmodule

`default_nettype wire

>>> src/bezier_newton_parameter_refine.sv
`default_nettype none

// One Newton step of projecting a point onto a cubic Bezier curve.
// The four control points are written through the configuration port
// (cfg_wen, cfg_index, cfg_data); indexes beyond the last register are ignored.
// Each item on the query channel carries a point and its current parameter u;
// the answer channel returns one item with u - f/f', a flag for a zero f'
// (u returned unchanged) and a flag for a clipped result.
// The block is a single stall-as-a-whole pipeline of 150 register stages:
// three de Casteljau levels of four stages each, a product and sum section,
// and a restoring divider that settles one quotient bit per stage over 128
// stages. A new item is taken every cycle in which query.ready is high.
// The output register is the last stage, so query.ready stays high while the
// output is empty or being taken; when the receiver holds answer.ready low
// with a result waiting, every stage holds and query.ready drops.
// Reset clears the control points to zero and empties the pipeline.
// Control points are expected to change only while no item is in flight.
module bezier_newton_parameter_refine #(
  parameter int COORD_WIDTH = bnpr_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = bnpr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  bnpr_query_if.sink                          query,
  bnpr_answer_if.source                       answer,
  input  logic                                cfg_wen,
  input  logic [bnpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic signed [COORD_WIDTH-1:0]       cfg_data
);
  import bnpr_pkg::*;

  // Stage numbers of the pipeline registers.
  localparam int S_IN     = 0;
  localparam int S_L1     = S_IN + MUL_LAT + 1;
  localparam int S_L2     = S_L1 + MUL_LAT + 1;
  localparam int S_Q      = S_L2 + MUL_LAT + 1;
  localparam int S_DX     = S_Q + 1;
  localparam int S_PR     = S_DX + MUL_LAT;
  localparam int S_SUM    = S_PR + 1;
  localparam int S_DEN    = S_SUM + 1;
  localparam int S_DIV    = S_DEN + 1;
  localparam int DIV_STEPS = 2 * XW;
  localparam int S_DIVEND = S_DIV + DIV_STEPS;
  localparam int S_QUO    = S_DIVEND + 1;
  localparam int S_OUT    = S_QUO + 1;

  localparam logic signed [XW-1:0] ONE_FX = XW'(1) <<< FRAC_BITS;
  localparam logic signed [XW+1:0] LIM_HI =
    {{(XW+3-COORD_WIDTH){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [XW+1:0] LIM_LO =
    {{(XW+3-COORD_WIDTH){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  function automatic logic signed [XW-1:0] sx(input logic signed [COORD_WIDTH-1:0] v);
    return {{(XW-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] sat_add(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b);
    logic [XW:0] s;
    s = {a[XW-1], a} + {b[XW-1], b};
    if (s[XW] != s[XW-1]) return s[XW] ? S64_MIN : S64_MAX;
    return $signed(s[XW-1:0]);
  endfunction

  function automatic logic signed [XW-1:0] sat_sub(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b);
    logic [XW:0] s;
    s = {a[XW-1], a} - {b[XW-1], b};
    if (s[XW] != s[XW-1]) return s[XW] ? S64_MIN : S64_MAX;
    return $signed(s[XW-1:0]);
  endfunction

  function automatic logic [XW-1:0] mag(input logic signed [XW-1:0] v);
    return v[XW-1] ? XW'(-v) : XW'(v);
  endfunction

  // Pipeline control: everything advances together unless a finished result
  // is waiting on a stalled receiver.
  logic           en;
  logic [S_OUT:0] vld;

  assign en          = !vld[S_OUT] || answer.ready;
  assign query.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_OUT-1:0], query.valid};
    end
  end

  // Control points and the derivative control points that follow from them.
  // The derivative points are small multiples of coordinate differences and
  // never reach the 64-bit limits, so plain arithmetic is exact here.
  logic signed [COORD_WIDTH-1:0] ctrl [NREG];
  logic signed [XW-1:0] cq [4][2];
  logic signed [XW-1:0] cd1 [3][2];
  logic signed [XW-1:0] cd2 [2][2];
  logic signed [XW-1:0] cd1_next [3][2];
  logic signed [XW-1:0] cd2_next [2][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) ctrl[i] <= '0;
    end else if (cfg_wen && cfg_index < CFG_IDX_W'(NREG)) begin
      ctrl[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 2; k++) cq[i][k] = sx(ctrl[2*i+k]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 2; k++) begin
        cd1_next[i][k] = ((cq[i+1][k] - cq[i][k]) <<< 1) + (cq[i+1][k] - cq[i][k]);
      end
    end
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 2; k++) cd2_next[i][k] = (cd1_next[i+1][k] - cd1_next[i][k]) <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    cd1 <= cd1_next;
    cd2 <= cd2_next;
  end

  // Item fields travelling alongside the arithmetic.
  logic signed [COORD_WIDTH-1:0] u_pipe  [S_QUO+1];
  logic signed [COORD_WIDTH-1:0] px_pipe [S_Q+1];
  logic signed [COORD_WIDTH-1:0] py_pipe [S_Q+1];

  always_ff @(posedge clk) begin
    if (en) begin
      u_pipe[S_IN]  <= query.param_u;
      px_pipe[S_IN] <= query.point_x;
      py_pipe[S_IN] <= query.point_y;
      for (int s = 1; s <= S_QUO; s++) u_pipe[s] <= u_pipe[s-1];
      for (int s = 1; s <= S_Q; s++) begin
        px_pipe[s] <= px_pipe[s-1];
        py_pipe[s] <= py_pipe[s-1];
      end
    end
  end

  // De Casteljau, first level: curve (3 lerps per axis), first derivative
  // (2 per axis) and second derivative (1 per axis, which finishes it).
  logic signed [XW-1:0] omt1, t1, omt2, t2, omt3, t3;
  logic signed [XW-1:0] l1_a [12], l1_b [12], l1_pa [12], l1_pb [12], r1 [12];
  logic signed [XW-1:0] l2_a [6], l2_b [6], l2_pa [6], l2_pb [6], r2 [6];
  logic signed [XW-1:0] l3_pa [2], l3_pb [2], r3 [2];

  always_comb begin
    t1   = sx(u_pipe[S_IN]);
    omt1 = sat_sub(ONE_FX, t1);
    t2   = sx(u_pipe[S_L1]);
    omt2 = sat_sub(ONE_FX, t2);
    t3   = sx(u_pipe[S_L2]);
    omt3 = sat_sub(ONE_FX, t3);
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 3; j++) begin
        l1_a[2*j+k] = cq[j][k];
        l1_b[2*j+k] = cq[j+1][k];
      end
      for (int j = 0; j < 2; j++) begin
        l1_a[6+2*j+k] = cd1[j][k];
        l1_b[6+2*j+k] = cd1[j+1][k];
        l2_a[2*j+k]   = r1[2*j+k];
        l2_b[2*j+k]   = r1[2*(j+1)+k];
      end
      l1_a[10+k] = cd2[0][k];
      l1_b[10+k] = cd2[1][k];
      l2_a[4+k]  = r1[6+k];
      l2_b[4+k]  = r1[8+k];
    end
  end

  for (genvar i = 0; i < 12; i++) begin : g_l1
    bnpr_fxmul #(.FRAC_BITS(FRAC_BITS)) u_ma (
      .clk(clk), .en(en), .a(omt1), .b(l1_a[i]), .p(l1_pa[i]));
    bnpr_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mb (
      .clk(clk), .en(en), .a(t1), .b(l1_b[i]), .p(l1_pb[i]));
    always_ff @(posedge clk) begin
      if (en) r1[i] <= sat_add(l1_pa[i], l1_pb[i]);
    end
  end

  // Second level: curve (2 per axis) and first derivative (finished).
  for (genvar i = 0; i < 6; i++) begin : g_l2
    bnpr_fxmul #(.FRAC_BITS(FRAC_BITS)) u_ma (
      .clk(clk), .en(en), .a(omt2), .b(l2_a[i]), .p(l2_pa[i]));
    bnpr_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mb (
      .clk(clk), .en(en), .a(t2), .b(l2_b[i]), .p(l2_pb[i]));
    always_ff @(posedge clk) begin
      if (en) r2[i] <= sat_add(l2_pa[i], l2_pb[i]);
    end
  end

  // Third level: the curve point itself.
  for (genvar k = 0; k < 2; k++) begin : g_l3
    bnpr_fxmul #(.FRAC_BITS(FRAC_BITS)) u_ma (
      .clk(clk), .en(en), .a(omt3), .b(r2[k]), .p(l3_pa[k]));
    bnpr_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mb (
      .clk(clk), .en(en), .a(t3), .b(r2[2+k]), .p(l3_pb[k]));
    always_ff @(posedge clk) begin
      if (en) r3[k] <= sat_add(l3_pa[k], l3_pb[k]);
    end
  end

  // Derivatives wait for the curve point, then Q(u)-P is formed.
  logic signed [XW-1:0] d2_pipe [S_L1+1:S_DX][2];
  logic signed [XW-1:0] d1_pipe [S_L2+1:S_DX][2];
  logic signed [XW-1:0] dx, dy;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        d2_pipe[S_L1+1][k] <= r1[10+k];
        d1_pipe[S_L2+1][k] <= r2[4+k];
        for (int s = S_L1 + 2; s <= S_DX; s++) d2_pipe[s][k] <= d2_pipe[s-1][k];
        for (int s = S_L2 + 2; s <= S_DX; s++) d1_pipe[s][k] <= d1_pipe[s-1][k];
      end
      dx <= sat_sub(r3[0], sx(px_pipe[S_Q]));
      dy <= sat_sub(r3[1], sx(py_pipe[S_Q]));
    end
  end

  // Products that make up f and f', then their sums.
  logic signed [XW-1:0] pr_a [6], pr_b [6], pr [6];
  logic signed [XW-1:0] num_sum, part_a, part_b, num_den, den;

  always_comb begin
    pr_a[0] = dx;                 pr_b[0] = d1_pipe[S_DX][0];
    pr_a[1] = dy;                 pr_b[1] = d1_pipe[S_DX][1];
    pr_a[2] = d1_pipe[S_DX][0];   pr_b[2] = d1_pipe[S_DX][0];
    pr_a[3] = d1_pipe[S_DX][1];   pr_b[3] = d1_pipe[S_DX][1];
    pr_a[4] = dx;                 pr_b[4] = d2_pipe[S_DX][0];
    pr_a[5] = dy;                 pr_b[5] = d2_pipe[S_DX][1];
  end

  for (genvar i = 0; i < 6; i++) begin : g_pr
    bnpr_fxmul #(.FRAC_BITS(FRAC_BITS)) u_m (
      .clk(clk), .en(en), .a(pr_a[i]), .b(pr_b[i]), .p(pr[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_sum <= sat_add(pr[0], pr[1]);
      part_a  <= sat_add(pr[2], pr[3]);
      part_b  <= sat_add(pr[4], pr[5]);
      num_den <= num_sum;
      den     <= sat_add(part_a, part_b);
    end
  end

  // Restoring divider: the numerator magnitude, scaled by the fraction bits,
  // shifts out of the top of dv_nq while quotient bits shift in at the bottom.
  logic [XW-1:0]   dv_r  [S_DIV:S_DIVEND];
  logic [2*XW-1:0] dv_nq [S_DIV:S_DIVEND];
  logic [XW-1:0]   dv_md [S_DIV:S_DIVEND];
  logic            dv_neg [S_DIV:S_DIVEND];
  logic            dv_z   [S_DIV:S_DIVEND];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[S_DIV]   <= '0;
      dv_nq[S_DIV]  <= {{XW{1'b0}}, mag(num_den)} << FRAC_BITS;
      dv_md[S_DIV]  <= mag(den);
      dv_neg[S_DIV] <= num_den[XW-1] ^ den[XW-1];
      dv_z[S_DIV]   <= (den == '0);
    end
  end

  for (genvar s = S_DIV + 1; s <= S_DIVEND; s++) begin : g_div
    logic [XW:0] rr;
    logic        ge;
    always_comb begin
      rr = {dv_r[s-1], dv_nq[s-1][2*XW-1]};
      ge = rr >= {1'b0, dv_md[s-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[s]   <= ge ? XW'(rr - {1'b0, dv_md[s-1]}) : rr[XW-1:0];
        dv_nq[s]  <= {dv_nq[s-1][2*XW-2:0], ge};
        dv_md[s]  <= dv_md[s-1];
        dv_neg[s] <= dv_neg[s-1];
        dv_z[s]   <= dv_z[s-1];
      end
    end
  end

  // Signed quotient, then u minus it, clipped to the coordinate range (u itself when f' is zero).
  logic signed [XW-1:0]          quo;
  logic                          quo_z;
  logic signed [XW+1:0]          diff;
  logic signed [COORD_WIDTH-1:0] out_u;
  logic                          out_z, out_s;

  assign diff = {{2{u_pipe[S_QUO][COORD_WIDTH-1]}}, sx(u_pipe[S_QUO])}
              - {{2{quo[XW-1]}}, quo};

  always_ff @(posedge clk) begin
    if (en) begin
      quo   <= apply_sign(|dv_nq[S_DIVEND][2*XW-1:XW], dv_nq[S_DIVEND][XW-1:0],
                          dv_neg[S_DIVEND]);
      quo_z <= dv_z[S_DIVEND];
      if (quo_z) begin
        out_u <= u_pipe[S_QUO];
        out_z <= 1'b1;
        out_s <= 1'b0;
      end else if (diff > LIM_HI) begin
        out_u <= LIM_HI[COORD_WIDTH-1:0];
        out_z <= 1'b0;
        out_s <= 1'b1;
      end else if (diff < LIM_LO) begin
        out_u <= LIM_LO[COORD_WIDTH-1:0];
        out_z <= 1'b0;
        out_s <= 1'b1;
      end else begin
        out_u <= diff[COORD_WIDTH-1:0];
        out_z <= 1'b0;
        out_s <= 1'b0;
      end
    end
  end

  assign answer.valid            = vld[S_OUT];
  assign answer.refined_u        = out_u;
  assign answer.zero_denominator = out_z;
  assign answer.saturated        = out_s;

`ifndef ASSERT_OFF
  // A result waiting on a stalled receiver must hold the input off.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (answer.valid && !answer.ready) |-> !query.ready)
    else $error("input accepted while output stalled");

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !answer.valid)
    else $error("result presented right after reset");

  // The divider remainder ends below a non-zero divisor.
  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (vld[S_DIVEND] && !dv_z[S_DIVEND]) |-> (dv_r[S_DIVEND] < dv_md[S_DIVEND]))
    else $error("divider remainder out of range");

  // A clipped result sits on a range limit and never with a zero f'.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (answer.valid && answer.saturated) |->
      (!answer.zero_denominator &&
       (answer.refined_u == LIM_HI[COORD_WIDTH-1:0] ||
        answer.refined_u == LIM_LO[COORD_WIDTH-1:0])))
    else $error("saturated flag without a clipped result");
`endif

endmodule

`default_nettype wire
